### rtl/med3_pkg.sv
`timescale 1ns / 1ps

package med3_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;
  localparam int CFG_W   = 12;
  localparam int CFG_AW  = 2;

  // Stream word widths (tdata padded to whole bytes)
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = PIX_W + 2 * COORD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = CFG_AW'(1);

  // Default sizes
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  // 3x3 window, index row*3 + col, oldest column first
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Everything but the window that a queued word carries
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               med;   // emits the median centred one up, one left
    logic               bord;  // emits itself as a border pixel
  } side_t;

  typedef struct packed {
    win_t  win;
    side_t side;
  } item_t;

  // Queue write and head
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Compare and swap: smaller value goes to slot i
  function automatic win_t cmp_swap(input win_t w, input int i, input int j);
    win_t r;
    r = w;
    if (w[i] > w[j]) begin
      r[i] = w[j];
      r[j] = w[i];
    end
    return r;
  endfunction

  // Median-of-nine network, first three levels
  function automatic win_t net_a(input win_t w);
    win_t t;
    t = w;
    t = cmp_swap(t, 1, 2); t = cmp_swap(t, 4, 5); t = cmp_swap(t, 7, 8);
    t = cmp_swap(t, 0, 1); t = cmp_swap(t, 3, 4); t = cmp_swap(t, 6, 7);
    t = cmp_swap(t, 1, 2); t = cmp_swap(t, 4, 5); t = cmp_swap(t, 7, 8);
    return t;
  endfunction

  // Next three levels
  function automatic win_t net_b(input win_t w);
    win_t t;
    t = w;
    t = cmp_swap(t, 0, 3); t = cmp_swap(t, 5, 8); t = cmp_swap(t, 4, 7);
    t = cmp_swap(t, 3, 6); t = cmp_swap(t, 1, 4); t = cmp_swap(t, 2, 5);
    t = cmp_swap(t, 4, 7);
    return t;
  endfunction

  // Last three levels, median lands in slot 4
  function automatic logic [PIX_W-1:0] net_c(input win_t w);
    win_t t;
    t = w;
    t = cmp_swap(t, 4, 2);
    t = cmp_swap(t, 6, 4);
    t = cmp_swap(t, 4, 2);
    return t[4];
  endfunction

endpackage

### rtl/med3_front.sv
`timescale 1ns / 1ps

module med3_front import med3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] pixel_in
  input  logic [QLW-1:0]        q_level,
  output q_push_t               q_push
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WLW  = CW + 1;
  localparam int HLW  = RW + 1;
  localparam int CMPW = (WLW > CFG_W) ? WLW : CFG_W;
  localparam int CMPH = (HLW > CFG_W) ? HLW : CFG_W;
  localparam int RST_W_LIM = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int RST_H_LIM = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

  logic [WLW-1:0]   width_r;
  logic [HLW-1:0]   height_r;
  logic [WLW-1:0]   width_nxt;
  logic [HLW-1:0]   height_nxt;
  logic [CMPW-1:0]  wv;
  logic [CMPH-1:0]  hv;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [WLW-1:0]   col_inc;
  logic [HLW-1:0]   row_inc;
  logic             col_last;
  logic             row_last;
  logic             acc;
  logic             cls_med;
  logic             cls_bord;
  logic [QLW:0]     credit;

  logic [PIX_W-1:0] up_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_r;
  logic [PIX_W-1:0] mid_rd_r;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             s1_med_r;
  logic             s1_bord_r;

  win_t             win_r;
  win_t             win_nxt;

  // Clamp written sizes: zero acts as one, large values saturate
  always_comb begin
    wv = CMPW'(cfg_wdata);
    hv = CMPH'(cfg_wdata);
    if (cfg_wdata == '0) begin
      width_nxt  = WLW'(1);
      height_nxt = HLW'(1);
    end else begin
      width_nxt  = (wv > CMPW'(MAX_WIDTH))  ? WLW'(MAX_WIDTH)  : WLW'(wv);
      height_nxt = (hv > CMPH'(MAX_HEIGHT)) ? HLW'(MAX_HEIGHT) : HLW'(hv);
    end
  end

  // Room check: items in the queue plus the one in stage 1
  assign credit    = {1'b0, q_level} + {{QLW{1'b0}}, s1_valid_r};
  assign in_tready = credit < (QLW + 1)'(QDEPTH);
  assign acc       = in_tvalid & in_tready;

  // Position and classification
  assign col_inc  = {1'b0, col_r} + WLW'(1);
  assign row_inc  = {1'b0, row_r} + HLW'(1);
  assign col_last = col_inc >= width_r;
  assign row_last = row_inc >= height_r;
  assign cls_med  = (row_r >= RW'(2)) && (col_r >= CW'(2));
  assign cls_bord = (row_r == '0) || (col_r == '0) ||
                    (row_inc == height_r) || (col_inc == width_r);

  // Config registers and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WLW'(RST_W_LIM);
      height_r <= HLW'(RST_H_LIM);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH: begin
          width_r <= width_nxt;
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_FRAME_HEIGHT: begin
          height_r <= height_nxt;
          col_r    <= '0;
          row_r    <= '0;
        end
        default: ;
      endcase
    end else if (acc) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : RW'(row_inc);
      end else begin
        col_r <= CW'(col_inc);
      end
    end
  end

  // Line store one row up: read on accept, new pixel written in place
  always_ff @(posedge clk) begin
    if (acc) begin
      mid_rd_r       <= mid_mem[col_r];
      mid_mem[col_r] <= in_tdata[PIX_W-1:0];
    end
  end

  // Line store two rows up: takes the old middle value in the cycle after the accept
  always_ff @(posedge clk) begin
    if (acc) begin
      up_rd_r <= up_mem[col_r];
    end
    if (s1_valid_r) begin
      up_mem[s1_col_r] <= mid_rd_r;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_tdata[PIX_W-1:0];
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_med_r  <= cls_med;
      s1_bord_r <= cls_bord;
    end
  end

  // Window shifts one column left, new column from the stores and pixel
  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3]     = win_r[i*3 + 1];
      win_nxt[i*3 + 1] = win_r[i*3 + 2];
    end
    win_nxt[2] = up_rd_r;
    win_nxt[5] = mid_rd_r;
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // Only pixels that cause a result go into the queue
  always_comb begin
    q_push.valid          = s1_valid_r & (s1_med_r | s1_bord_r);
    q_push.item.win       = win_nxt;
    q_push.item.side.pix  = s1_pix_r;
    q_push.item.side.row  = COORD_W'(s1_row_r);
    q_push.item.side.col  = COORD_W'(s1_col_r);
    q_push.item.side.med  = s1_med_r;
    q_push.item.side.bord = s1_bord_r;
  end

endmodule

### rtl/med3_fifo.sv
`timescale 1ns / 1ps

module med3_fifo import med3_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  q_push_t        q_push,
  input  logic           q_pop,
  output q_head_t        q_head,
  output logic [QLW-1:0] q_level
);

  item_t          mem_r [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QLW-1:0] level_r;

  function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : p + QPW'(1);
  endfunction

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (q_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (q_push.valid && !q_pop) begin
        level_r <= level_r + QLW'(1);
      end else if (!q_push.valid && q_pop) begin
        level_r <= level_r - QLW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      mem_r[wr_ptr_r] <= q_push.item;
    end
  end

  assign q_head.valid = level_r != '0;
  assign q_head.item  = mem_r[rd_ptr_r];
  assign q_level      = level_r;

endmodule

### rtl/med3_back.sv
`timescale 1ns / 1ps

module med3_back import med3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  q_head_t                q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] pixel_out, [18:8] out_row, [29:19] out_col
  output logic                   out_tlast   // last_of_run
);

  localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  logic               p1_valid_r;
  logic               p2_valid_r;
  logic               p3_valid_r;
  win_t               p1_win_r;
  win_t               p2_win_r;
  side_t              p1_side_r;
  side_t              p2_side_r;
  side_t              p3_side_r;
  logic [PIX_W-1:0]   p3_med_r;
  logic               phase_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pix_r;
  logic [COORD_W-1:0] out_row_r;
  logic [COORD_W-1:0] out_col_r;
  logic               out_last_r;

  logic               first;
  logic [PIX_W-1:0]   word_pix;
  logic [COORD_W-1:0] word_row;
  logic [COORD_W-1:0] word_col;
  logic               word_last;
  logic               out_load;
  logic               p3_done;
  logic               adv;

  // Word from the last stage: median first, then the border pixel
  always_comb begin
    first     = p3_side_r.med && !phase_r;
    word_pix  = first ? p3_med_r : p3_side_r.pix;
    word_row  = first ? p3_side_r.row - COORD_W'(1) : p3_side_r.row;
    word_col  = first ? p3_side_r.col - COORD_W'(1) : p3_side_r.col;
    word_last = first ? !p3_side_r.bord : 1'b1;
  end

  assign out_load = !out_valid_r || out_tready;
  assign p3_done  = p3_valid_r && out_load && word_last;
  assign adv      = !p3_valid_r || p3_done;
  assign q_pop    = adv && q_head.valid;

  // Pipeline and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        p1_valid_r <= q_pop;
        p2_valid_r <= p1_valid_r;
        p3_valid_r <= p2_valid_r;
        phase_r    <= 1'b0;
      end else if (p3_valid_r && out_load) begin
        phase_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= p3_valid_r;
      end
    end
  end

  // Median network, three levels per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_win_r  <= net_a(q_head.item.win);
      p1_side_r <= q_head.item.side;
      p2_win_r  <= net_b(p1_win_r);
      p2_side_r <= p1_side_r;
      p3_med_r  <= net_c(p2_win_r);
      p3_side_r <= p2_side_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r  <= word_pix;
      out_row_r  <= word_row;
      out_col_r  <= word_col;
      out_last_r <= word_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_col_r, out_row_r, out_pix_r};
  assign out_tlast  = out_last_r;

endmodule

### rtl/median_filter_3x3_gray_unit.sv
`timescale 1ns / 1ps

// 3x3 median filter for a raster stream of 8-bit gray pixels.
// Input stream in_*: one pixel per word in in_tdata[7:0], row by row.
// Output stream out_*: tdata = {pad, col, row, pixel}; tlast marks the last
// word caused by one input pixel. An input pixel at (r, c) releases the
// median centred at (r-1, c-1) when r >= 2 and c >= 2, then itself when it
// lies in the first or last row or column; most pixels release one word.
// Config port: cfg_we writes cfg_wdata to frame_width (index 0) or
// frame_height (index 1) and restarts the frame at row 0, column 0.
// Throughput: one pixel per clock while the queue has room; a pixel that
// causes two words holds the last network stage until both are sent. From
// the accepting edge a pixel passes a line store read, the queue, three
// median network stages and the output register on its way to out_*.
// Reset: frame counters cleared, size 640 x 480. Line store contents are
// undefined; they only reach an output after being written in the frame.
// When out_tready is low the output word holds, the median pipeline stops
// and the four-entry queue fills; in_tready drops once it has no room.

module median_filter_3x3_gray_unit import med3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] pixel_out, [18:8] out_row, [29:19] out_col
  output logic                   out_tlast   // last_of_run
);

  q_push_t        q_push;
  q_head_t        q_head;
  logic           q_pop;
  logic [QLW-1:0] q_level;

  med3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_level   (q_level),
    .q_push    (q_push)
  );

  med3_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_level (q_level)
  );

  med3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### rtl/med3_checker.sv
`timescale 1ns / 1ps

module med3_checker import med3_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Out of reset: nothing to send, room for input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // A word that is not last is a median, centred off the first row and column
  a_median_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tdata[PIX_W+COORD_W-1:PIX_W] != '0 && out_tdata[OUT_FIELD_W-1:PIX_W+COORD_W] != '0)
    else $error("median word on a border position");

  // Median word is followed by its border word without a gap when taken
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second word of a pair missing");

endmodule

bind median_filter_3x3_gray_unit med3_checker u_med3_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import med3_pkg::*;

  localparam int RAND_ITEMS   = 1200;
  localparam int DRAIN_CYCLES = 12;    // margin for the pipeline to drain
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int CALM_FROM    = 400;
  localparam int CALM_TO      = 700;

  // Indexes with no register behind them
  localparam logic [CFG_AW-1:0] REG_SPARE_A = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_SPARE_B = CFG_AW'(3);

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } result_t;

  typedef enum logic {ST_PIXEL, ST_WRITE} step_kind_e;
  typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_BAND} pattern_e;

  typedef struct packed {
    step_kind_e        kind;
    logic [CFG_AW-1:0] addr;
    logic [CFG_W-1:0]  val;    // pixel in the low byte for ST_PIXEL
    logic              typed;  // exp holds the one word this pixel must cause
    result_t           exp;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Shared between stimulus and receiver
  logic calm = 1'b0;
  logic hold_req = 1'b0;

  result_t due_words[$];
  step_t   plan[$];
  int      mismatches = 0;

  // Filter state as the testbench sees it
  logic [PIX_W-1:0] two_up_line [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] one_up_line [DEF_MAX_WIDTH];
  win_t             win = '0;
  int               cur_row = 0;
  int               cur_col = 0;
  logic [CFG_W-1:0] frame_w_reg = CFG_W'(RST_WIDTH);
  logic [CFG_W-1:0] frame_h_reg = CFG_W'(RST_HEIGHT);

  median_filter_3x3_gray_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Output checker; words listed as pixel/row/col/last
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pix  = out_tdata[PIX_W-1:0];
      got.row  = out_tdata[PIX_W +: COORD_W];
      got.col  = out_tdata[PIX_W + COORD_W +: COORD_W];
      got.last = out_tlast;
      if (due_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, got %0d/%0d/%0d/%0d",
                 $time, got.pix, got.row, got.col, got.last);
      end else begin
        want = due_words.pop_front();
        if (got != want || (out_tdata >> OUT_FIELD_W) != 0) begin
          mismatches++;
          $display("%0t: mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d pad %0h",
                   $time, want.pix, want.row, want.col, want.last,
                   got.pix, got.row, got.col, got.last, out_tdata >> OUT_FIELD_W);
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  // Register value to frame size: zero acts as one, saturate at the maximum
  function automatic int eff_size(input logic [CFG_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] median_of_nine(input win_t w);
    logic [PIX_W-1:0] s [9];
    logic [PIX_W-1:0] t;
    int i, j;
    for (i = 0; i < 9; i++) s[i] = w[i];
    // insertion sort, median ends up in the middle slot
    for (i = 1; i < 9; i++) begin
      t = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > t) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = t;
    end
    return s[4];
  endfunction

  // One pixel into the filter; returns how many words it releases
  function automatic int filter_pixel(input logic [PIX_W-1:0] pix,
                                      output result_t first, output result_t second);
    int w, h, n, i;
    logic [PIX_W-1:0] up, mid;
    result_t self_word;
    w = eff_size(frame_w_reg, DEF_MAX_WIDTH);
    h = eff_size(frame_h_reg, DEF_MAX_HEIGHT);
    up  = two_up_line[cur_col];
    mid = one_up_line[cur_col];
    for (i = 0; i < 3; i++) begin
      win[i * 3]     = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = pix;
    two_up_line[cur_col] = mid;
    one_up_line[cur_col] = pix;

    first = '0;
    second = '0;
    n = 0;
    // median centred one row up, one column left
    if (cur_row >= 2 && cur_col >= 2) begin
      first = '{pix: median_of_nine(win), row: COORD_W'(cur_row - 1),
                col: COORD_W'(cur_col - 1), last: 1'b0};
      n = 1;
    end
    // border pass-through
    if (cur_row == 0 || cur_col == 0 || cur_row + 1 == h || cur_col + 1 == w) begin
      self_word = '{pix: pix, row: COORD_W'(cur_row), col: COORD_W'(cur_col), last: 1'b0};
      if (n == 0) first = self_word;
      else second = self_word;
      n++;
    end
    if (n == 1) first.last = 1'b1;
    else if (n == 2) second.last = 1'b1;

    if (cur_col + 1 >= w) begin
      cur_col = 0;
      cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
    return n;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(input pattern_e pat,
                                                  input logic [PIX_W-1:0] base);
    case (pat)
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_BAND:    return base + PIX_W'($urandom_range(0, 3));
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly 3..10, sometimes degenerate or oversized
  function automatic logic [CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CFG_W'($urandom_range(0, 2));
    if (r < 10) begin
      case ($urandom_range(0, 2))
        0:       return CFG_W'(2048);
        1:       return CFG_W'(4095);
        default: return CFG_W'($urandom_range(2049, 4095));
      endcase
    end
    return CFG_W'($urandom_range(3, 10));
  endfunction

  // Wait for the block to go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_FRAME_WIDTH: begin
        frame_w_reg = val;
        cur_row = 0;
        cur_col = 0;
      end
      REG_FRAME_HEIGHT: begin
        frame_h_reg = val;
        cur_row = 0;
        cur_col = 0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                            input result_t typed_word);
    result_t r0, r1;
    int n;
    if (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = filter_pixel(pix, r0, r1);
    if (typed) begin
      due_words.push_back(typed_word);
    end else begin
      if (n > 0) due_words.push_back(r0);
      if (n > 1) due_words.push_back(r1);
    end
  endtask

  task automatic add_write(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] val);
    plan.push_back('{kind: ST_WRITE, addr: addr, val: val, typed: 1'b0, exp: '0});
  endtask

  task automatic add_pixel(input logic [PIX_W-1:0] pix);
    plan.push_back('{kind: ST_PIXEL, addr: '0, val: CFG_W'(pix), typed: 1'b0, exp: '0});
  endtask

  // Border pixel that passes through as the only word
  task automatic add_border(input logic [PIX_W-1:0] pix, input int row, input int col);
    plan.push_back('{kind: ST_PIXEL, addr: '0, val: CFG_W'(pix), typed: 1'b1,
                     exp: '{pix: pix, row: COORD_W'(row), col: COORD_W'(col),
                            last: 1'b1}});
  endtask

  initial begin : stimulus
    int rand_sent, n, frame, fw, fh, k, pick;
    bit hold_done;
    pattern_e pat;
    logic [PIX_W-1:0] base;

    rand_sent = 0;
    hold_done = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset size, 3x3 frame, degenerate and oversized sizes,
    // spare indexes, frame wrap
    add_border(8'h00, 0, 0);
    add_border(8'hFF, 0, 1);
    add_border(8'h5A, 0, 2);
    add_write(REG_FRAME_WIDTH, 12'd3);
    add_write(REG_FRAME_HEIGHT, 12'd3);
    add_pixel(8'h00); add_pixel(8'hFF); add_pixel(8'h00);
    add_pixel(8'hFF); add_pixel(8'h80); add_pixel(8'hFF);
    add_pixel(8'h00); add_pixel(8'hFF); add_pixel(8'h10);
    add_write(REG_FRAME_WIDTH, 12'd0);
    add_write(REG_FRAME_HEIGHT, 12'hFFF);
    add_border(8'hAA, 0, 0);
    add_border(8'h55, 1, 0);
    add_write(REG_SPARE_A, 12'hFFF);   // no restart
    add_border(8'h01, 2, 0);
    add_write(REG_SPARE_B, 12'h000);
    add_write(REG_FRAME_WIDTH, 12'd2);
    add_write(REG_FRAME_HEIGHT, 12'd2);
    add_border(8'h7F, 0, 0);
    add_border(8'h80, 0, 1);
    add_border(8'hFE, 1, 0);
    add_border(8'h01, 1, 1);
    add_border(8'h33, 0, 0);

    foreach (plan[i]) begin
      if (plan[i].kind == ST_WRITE) configure(plan[i].addr, plan[i].val);
      else send_pixel(plan[i].val[PIX_W-1:0], plan[i].typed, plan[i].exp);
    end

    // Random phases: new size or a spare-index write, then mostly whole frames of random content
    while (rand_sent < RAND_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        configure($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_W'($urandom));
      end else begin
        if (pick < 3 || pick >= 5) configure(REG_FRAME_WIDTH, pick_size());
        if (pick >= 3) configure(REG_FRAME_HEIGHT, pick_size());
      end
      fw = eff_size(frame_w_reg, DEF_MAX_WIDTH);
      fh = eff_size(frame_h_reg, DEF_MAX_HEIGHT);
      frame = fw * fh;
      if (fw > 16 || fh > 16) n = $urandom_range(1, 40);
      else if ($urandom_range(0, 3) != 0) n = frame * $urandom_range(1, 3);
      else n = $urandom_range(1, 2 * frame);
      if (n > 300) n = 300;
      // long receiver hold while the sender keeps pushing
      if (!hold_done && rand_sent >= CALM_FROM + 50) begin
        hold_done = 1;
        hold_req <= 1'b1;
        if (n < 120) n = 120;
      end
      pat = pattern_e'($urandom_range(0, 2));
      base = PIX_W'($urandom_range(0, 252));
      for (k = 0; k < n; k++) begin
        calm <= (rand_sent >= CALM_FROM && rand_sent < CALM_TO);
        send_pixel(draw_pixel(pat, base), 1'b0, '0);
        rand_sent++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
